// ===== rtl/cpo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the convex polygon overlap test.
package cpo_pkg;

  localparam int MAX_VERTICES_DFLT = 16;

  localparam int COORD_W = 16;
  localparam int AXIS_W  = COORD_W + 1;
  localparam int PROD_W  = AXIS_W + COORD_W;
  localparam int DOT_W   = PROD_W + 1;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  // y in the upper half, x in the lower half
  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  // one vertex pair on its way through the projection pipeline
  typedef struct packed {
    logic valid;
    logic use_a;
    logic use_b;
    logic first;
  } proj_tok_t;

  typedef struct packed {
    logic busy;
    logic separated;
  } proj_stat_t;

endpackage

// ===== rtl/cpo_vertex_mem.sv =====
`timescale 1ns / 1ps
// Vertex store: one write port, one read port with registered read data.
module cpo_vertex_mem #(
  parameter int DEPTH = cpo_pkg::MAX_VERTICES_DFLT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  cpo_pkg::vertex_t wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output cpo_pkg::vertex_t rd_data_o
);

  cpo_pkg::vertex_t mem_q [DEPTH];
  cpo_pkg::vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/cpo_proj_unit.sv =====
`timescale 1ns / 1ps
// Projection pipeline: dot products of both polygons on one axis and their min/max bounds.
module cpo_proj_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpo_pkg::proj_tok_t  tok_i,
  input  cpo_pkg::axis_t      axis_x_i,
  input  cpo_pkg::axis_t      axis_y_i,
  input  cpo_pkg::vertex_t    vtx_a_i,
  input  cpo_pkg::vertex_t    vtx_b_i,
  output cpo_pkg::proj_stat_t stat_o
);

  cpo_pkg::proj_tok_t tok_s1_q, tok_s2_q, tok_s3_q;

  cpo_pkg::prod_t prod_ax_d, prod_ay_d, prod_bx_d, prod_by_d;
  cpo_pkg::prod_t prod_ax_q, prod_ay_q, prod_bx_q, prod_by_q;
  cpo_pkg::dot_t  dot_a_d, dot_b_d;
  cpo_pkg::dot_t  dot_a_q, dot_b_q;
  cpo_pkg::dot_t  lo_a_q, hi_a_q, lo_b_q, hi_b_q;

  // token stages follow the memory read latency, the multiply and the add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_s1_q <= '0;
      tok_s2_q <= '0;
      tok_s3_q <= '0;
    end else begin
      tok_s1_q <= tok_i;
      tok_s2_q <= tok_s1_q;
      tok_s3_q <= tok_s2_q;
    end
  end

  always_comb begin
    prod_ax_d = axis_x_i * $signed(vtx_a_i.x);
    prod_ay_d = axis_y_i * $signed(vtx_a_i.y);
    prod_bx_d = axis_x_i * $signed(vtx_b_i.x);
    prod_by_d = axis_y_i * $signed(vtx_b_i.y);
    dot_a_d   = cpo_pkg::dot_t'(prod_ax_q) + cpo_pkg::dot_t'(prod_ay_q);
    dot_b_d   = cpo_pkg::dot_t'(prod_bx_q) + cpo_pkg::dot_t'(prod_by_q);
  end

  always_ff @(posedge clk_i) begin
    prod_ax_q <= prod_ax_d;
    prod_ay_q <= prod_ay_d;
    prod_bx_q <= prod_bx_d;
    prod_by_q <= prod_by_d;
    dot_a_q   <= dot_a_d;
    dot_b_q   <= dot_b_d;
    // each projection may lower the low bound or raise the high bound; the first one seeds them
    if (tok_s3_q.valid && tok_s3_q.use_a) begin
      if (tok_s3_q.first || dot_a_q < lo_a_q) begin
        lo_a_q <= dot_a_q;
      end
      if (tok_s3_q.first || dot_a_q > hi_a_q) begin
        hi_a_q <= dot_a_q;
      end
    end
    if (tok_s3_q.valid && tok_s3_q.use_b) begin
      if (tok_s3_q.first || dot_b_q < lo_b_q) begin
        lo_b_q <= dot_b_q;
      end
      if (tok_s3_q.first || dot_b_q > hi_b_q) begin
        hi_b_q <= dot_b_q;
      end
    end
  end

  assign stat_o.busy      = tok_s1_q.valid | tok_s2_q.valid | tok_s3_q.valid;
  // touching intervals still count as overlapping
  assign stat_o.separated = (lo_b_q > hi_a_q) || (lo_a_q > hi_b_q);

endmodule

// ===== rtl/convex_polygon_overlap_test.sv =====
`timescale 1ns / 1ps
// Top level of the convex polygon overlap test: request sequencer and the two vertex stores.
// Two convex polygons are written vertex by vertex into stores A and B (action 0 and 1,
// one request per cycle); a test request (action 2) gives the vertex counts and returns one
// result, overlap = 1 unless some edge normal of A or B separates the two projections.
// Counts above MAX_VERTICES saturate, a zero count answers 0, and entries never loaded read
// as garbage. A test holds off further requests until it finishes: each edge reads its two
// end points through the store's single read port, then streams max(na, nb) vertex pairs
// through a four-stage read/multiply/add/bound pipeline and waits for it to drain. A
// finished result sits in an output register, so new requests are taken while it waits.
module convex_polygon_overlap_test #(
  parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  vertex_slot_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic [4:0]  count_a_i,
  input  logic [4:0]  count_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        overlap_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b000_0001,
    S_RD_PREV = 7'b000_0010,
    S_RD_CUR  = 7'b000_0100,
    S_AXIS    = 7'b000_1000,
    S_PROJ    = 7'b001_0000,
    S_DRAIN   = 7'b010_0000,
    S_FINISH  = 7'b100_0000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic          pass_q, pass_d;
  logic [AW-1:0] e_q, e_d;
  logic [AW-1:0] i_q, i_d;
  logic [CW-1:0] na_q, na_d, nb_q, nb_d, maxn_q, maxn_d;
  logic          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic          overlap_q;
  logic          finish;

  logic          in_acc;
  logic          slot_ok;
  logic          wr_a_en, wr_b_en;
  logic [CW-1:0] sat_a, sat_b;
  logic [CW-1:0] np, np_m1, maxn_m1;
  logic [AW-1:0] prev_idx, edge_addr, rd_addr_a, rd_addr_b;

  cpo_pkg::vertex_t    wr_vtx, rd_a, rd_b, cur_vtx, prev_vtx_q;
  cpo_pkg::axis_t      axis_x_d, axis_y_d, axis_x_q, axis_y_q;
  cpo_pkg::proj_tok_t  tok;
  cpo_pkg::proj_stat_t proj_st;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign slot_ok = (int'(vertex_slot_i) < MAX_VERTICES);
  assign wr_a_en = in_acc && (cpo_pkg::action_e'(action_i) == cpo_pkg::ACT_LOAD_A) && slot_ok;
  assign wr_b_en = in_acc && (cpo_pkg::action_e'(action_i) == cpo_pkg::ACT_LOAD_B) && slot_ok;
  assign wr_vtx  = '{y: coord_y_i, x: coord_x_i};

  assign sat_a = (int'(count_a_i) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_a_i);
  assign sat_b = (int'(count_b_i) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_b_i);

  assign np       = pass_q ? nb_q : na_q;
  assign np_m1    = np - 1'b1;
  assign maxn_m1  = maxn_q - 1'b1;
  assign prev_idx = (e_q == '0) ? np_m1[AW-1:0] : e_q - 1'b1;

  // edge end points come from the polygon of the current pass
  assign edge_addr = (state_q == S_RD_PREV) ? prev_idx : e_q;
  assign rd_addr_a = ((state_q == S_RD_PREV || state_q == S_RD_CUR) && !pass_q) ? edge_addr : i_q;
  assign rd_addr_b = ((state_q == S_RD_PREV || state_q == S_RD_CUR) && pass_q) ? edge_addr : i_q;

  cpo_vertex_mem #(
    .DEPTH(MAX_VERTICES)
  ) u_mem_a (
    .clk_i    (clk_i),
    .wr_en_i  (wr_a_en),
    .wr_addr_i(AW'(vertex_slot_i)),
    .wr_data_i(wr_vtx),
    .rd_addr_i(rd_addr_a),
    .rd_data_o(rd_a)
  );

  cpo_vertex_mem #(
    .DEPTH(MAX_VERTICES)
  ) u_mem_b (
    .clk_i    (clk_i),
    .wr_en_i  (wr_b_en),
    .wr_addr_i(AW'(vertex_slot_i)),
    .wr_data_i(wr_vtx),
    .rd_addr_i(rd_addr_b),
    .rd_data_o(rd_b)
  );

  assign cur_vtx = pass_q ? rd_b : rd_a;

  // axis is the edge normal (-dy, dx)
  always_comb begin
    axis_y_d = cpo_pkg::axis_t'($signed(cur_vtx.x)) - cpo_pkg::axis_t'($signed(prev_vtx_q.x));
    axis_x_d = cpo_pkg::axis_t'($signed(prev_vtx_q.y)) - cpo_pkg::axis_t'($signed(cur_vtx.y));
  end

  assign tok.valid = (state_q == S_PROJ);
  assign tok.use_a = (CW'(i_q) < na_q);
  assign tok.use_b = (CW'(i_q) < nb_q);
  assign tok.first = (i_q == '0);

  cpo_proj_unit u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok),
    .axis_x_i(axis_x_q),
    .axis_y_i(axis_y_q),
    .vtx_a_i (rd_a),
    .vtx_b_i (rd_b),
    .stat_o  (proj_st)
  );

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    e_d     = e_q;
    i_d     = i_q;
    na_d    = na_q;
    nb_d    = nb_q;
    maxn_d  = maxn_q;
    res_d   = res_q;
    finish  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && cpo_pkg::action_e'(action_i) == cpo_pkg::ACT_TEST) begin
          na_d   = sat_a;
          nb_d   = sat_b;
          maxn_d = (sat_a > sat_b) ? sat_a : sat_b;
          pass_d = 1'b0;
          e_d    = '0;
          if (sat_a == '0 || sat_b == '0) begin
            res_d   = 1'b0;
            state_d = S_FINISH;
          end else begin
            state_d = S_RD_PREV;
          end
        end
      end
      S_RD_PREV: state_d = S_RD_CUR;
      S_RD_CUR:  state_d = S_AXIS;
      S_AXIS: begin
        i_d     = '0;
        state_d = S_PROJ;
      end
      S_PROJ: begin
        if (CW'(i_q) == maxn_m1) begin
          state_d = S_DRAIN;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // bounds are final once the pipeline is empty
        if (!proj_st.busy) begin
          if (proj_st.separated) begin
            res_d   = 1'b0;
            state_d = S_FINISH;
          end else if (CW'(e_q) == np_m1) begin
            if (pass_q) begin
              res_d   = 1'b1;
              state_d = S_FINISH;
            end else begin
              pass_d  = 1'b1;
              e_d     = '0;
              state_d = S_RD_PREV;
            end
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_RD_PREV;
          end
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      e_q         <= '0;
      i_q         <= '0;
      na_q        <= '0;
      nb_q        <= '0;
      maxn_q      <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      e_q         <= e_d;
      i_q         <= i_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      maxn_q      <= maxn_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_CUR) begin
      prev_vtx_q <= cur_vtx;
    end
    if (state_q == S_AXIS) begin
      axis_x_q <= axis_x_d;
      axis_y_q <= axis_y_d;
    end
    if (finish) begin
      overlap_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result appeared without a finished test");

  a_idle_pipe_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !proj_st.busy)
    else $error("projection pipeline busy while idle");

  a_proj_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROJ) |-> (CW'(i_q) < maxn_q))
    else $error("vertex index beyond vertex count");

  a_edge_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_PREV) |-> (CW'(e_q) < np))
    else $error("edge index beyond polygon size");

endmodule

// ===== tb/convex_polygon_overlap_test_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the convex polygon overlap test: directed table, then random
// polygon pairs checked against a local separating-axis predictor.
module convex_polygon_overlap_test_test;

  localparam int NVERT        = 16;
  localparam int ITEMS        = 2000;
  localparam int DRAIN_CYCLES = 800;
  localparam int LIMIT_CYCLES = 10_000_000;

  localparam logic [1:0] ACT_LOAD_A = cpo_pkg::ACT_LOAD_A;
  localparam logic [1:0] ACT_LOAD_B = cpo_pkg::ACT_LOAD_B;
  localparam logic [1:0] ACT_TEST   = cpo_pkg::ACT_TEST;
  localparam logic [1:0] ACT_NONE   = cpo_pkg::ACT_NONE;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i      = ACT_NONE;
  logic [3:0]        vertex_slot_i = 4'd0;
  logic signed [15:0] coord_x_i    = 16'sd0;
  logic signed [15:0] coord_y_i    = 16'sd0;
  logic [4:0]        count_a_i     = 5'd0;
  logic [4:0]        count_b_i     = 5'd0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              overlap_o;

  convex_polygon_overlap_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .vertex_slot_i (vertex_slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .count_a_i     (count_a_i),
    .count_b_i     (count_b_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .overlap_o     (overlap_o)
  );

  typedef struct {
    logic [1:0] act;
    int         slot;
    int         x;
    int         y;
    int         ca;
    int         cb;
    bit         known;
    logic       val;
  } plan_row_t;

  cpo_pkg::vertex_t shape_a [NVERT];
  cpo_pkg::vertex_t shape_b [NVERT];
  bit        loaded_a [NVERT];
  bit        loaded_b [NVERT];
  logic      overlap_q [$];
  plan_row_t plan [32];
  int        plan_len   = 0;
  int        fail_count = 0;
  int        sent       = 0;
  int        idle_mode  = IDLE_NONE;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("convex_polygon_overlap_test_test NOT OK");
    $finish;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic cpo_pkg::vertex_t corner(bit from_a, int i);
    return from_a ? shape_a[i] : shape_b[i];
  endfunction

  // interval of one polygon projected on the axis
  function automatic void span(input bit from_a, input int n, input longint ax,
                               input longint ay, output longint lo, output longint hi);
    cpo_pkg::vertex_t v;
    longint  d;
    lo = 0;
    hi = 0;
    for (int i = 0; i < n; i++) begin
      v = corner(from_a, i);
      d = ax * longint'(v.x) + ay * longint'(v.y);
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // 1 when no edge normal of the first polygon separates the pair
  function automatic bit edges_clear(bit from_a, int np, int nq);
    cpo_pkg::vertex_t cur, prv;
    longint  ax, ay, lo_p, hi_p, lo_q, hi_q;
    for (int e = 0; e < np; e++) begin
      cur = corner(from_a, e);
      prv = corner(from_a, (e == 0) ? np - 1 : e - 1);
      ax  = longint'(prv.y) - longint'(cur.y);
      ay  = longint'(cur.x) - longint'(prv.x);
      span(from_a, np, ax, ay, lo_p, hi_p);
      span(!from_a, nq, ax, ay, lo_q, hi_q);
      if (lo_q > hi_p || lo_p > hi_q) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic predict_overlap(int ca, int cb);
    int na, nb;
    na = (ca > NVERT) ? NVERT : ca;
    nb = (cb > NVERT) ? NVERT : cb;
    if (na == 0 || nb == 0) return 1'b0;
    return edges_clear(1'b1, na, nb) && edges_clear(1'b0, nb, na);
  endfunction

  // pick a vertex count whose entries have all been loaded
  function automatic int legal_count(bit from_a, bit wide);
    int p;
    p = 0;
    while (p < NVERT && (from_a ? loaded_a[p] : loaded_b[p])) p++;
    if (p == NVERT && wide) return $urandom_range(0, 31);
    return $urandom_range(0, p);
  endfunction

  function automatic int rim(int k);
    case (k % 16)
      0: return 1024;   1: return 946;    2: return 724;    3: return 392;
      4: return 0;      5: return -392;   6: return -724;   7: return -946;
      8: return -1024;  9: return -946;   10: return -724;  11: return -392;
      12: return 0;     13: return 392;   14: return 724;   default: return 946;
    endcase
  endfunction

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int clamp(int v, int lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic int pick_vertices();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(1, 2);
    if (roll < 85) return $urandom_range(3, 6);
    if (roll < 95) return $urandom_range(7, 12);
    return $urandom_range(13, 16);
  endfunction

  function automatic int pick_radius();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 2000);
    if (roll < 95) return $urandom_range(2001, 30000);
    return 32767;
  endfunction

  function automatic void plan_row(logic [1:0] act, int slot, int x, int y, int ca, int cb,
                                   bit known, logic val);
    plan[plan_len] = '{act, slot, x, y, ca, cb, known, val};
    plan_len++;
  endfunction

  task automatic report(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // send one request, hold it until taken, then update the local stores
  task automatic issue(input logic [1:0] act, input int slot, input int x, input int y,
                       input int ca, input int cb, input bit known = 1'b0,
                       input logic val = 1'b0);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 45 : ((idle_mode == IDLE_BOTH) ? 33 : 0);
    while (chance(pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    vertex_slot_i <= 4'(slot);
    coord_x_i     <= 16'(x);
    coord_y_i     <= 16'(y);
    count_a_i     <= 5'(ca);
    count_b_i     <= 5'(cb);
    do @(posedge clk_i); while (in_stall_o);
    case (act)
      ACT_LOAD_A: begin
        shape_a[slot % NVERT]  = '{y: 16'(y), x: 16'(x)};
        loaded_a[slot % NVERT] = 1'b1;
      end
      ACT_LOAD_B: begin
        shape_b[slot % NVERT]  = '{y: 16'(y), x: 16'(x)};
        loaded_b[slot % NVERT] = 1'b1;
      end
      ACT_TEST: overlap_q.push_back(known ? val : predict_overlap(ca, cb));
      default: ;
    endcase
    if (act != ACT_NONE) sent++;
  endtask

  // load a convex polygon: n of the 16 rim directions around a center
  task automatic load_convex(bit to_a, int n, int cx, int cy, int r, bit mirror);
    int rot, left, slot;
    rot  = $urandom_range(0, 15);
    left = n;
    slot = 0;
    for (int k = 0; k < NVERT && left > 0; k++) begin
      if ($urandom_range(0, NVERT - 1 - k) < left) begin
        issue(to_a ? ACT_LOAD_A : ACT_LOAD_B, mirror ? n - 1 - slot : slot,
              cx + rim(k + rot) * r / 1024, cy + rim(k + rot + 12) * r / 1024,
              $urandom_range(0, 31), $urandom_range(0, 31));
        slot++;
        left--;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (idle_mode == IDLE_RECV) ? chance(45) :
                   ((idle_mode == IDLE_BOTH) ? chance(33) : 1'b0);
  end

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (overlap_q.size() == 0) begin
        report($sformatf("unexpected result: overlap=%0b", overlap_o));
      end else begin
        want = overlap_q.pop_front();
        if (overlap_o !== want)
          report($sformatf("overlap mismatch: expected %0b, got %0b", want, overlap_o));
      end
    end
  end

  initial begin
    int roll, na, nb, ra, rb, s, acx, acy, bcx, bcy, ca, cb;
    na  = 0;
    ra  = 1;
    acx = 0;
    acy = 0;

    // small triangles, separated, then touching along A's long side
    plan_row(ACT_LOAD_A, 0, 0, 0, 31, 0, 1'b0, 1'b0);
    plan_row(ACT_LOAD_A, 1, 10, 0, 0, 31, 1'b0, 1'b0);
    plan_row(ACT_LOAD_A, 2, 0, 10, 16, 16, 1'b0, 1'b0);
    plan_row(ACT_LOAD_B, 0, 20, 20, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_LOAD_B, 1, 30, 20, 31, 31, 1'b0, 1'b0);
    plan_row(ACT_LOAD_B, 2, 20, 30, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_TEST, 15, -1, -1, 3, 3, 1'b0, 1'b0);
    plan_row(ACT_TEST, 0, 0, 0, 0, 3, 1'b1, 1'b0);
    plan_row(ACT_TEST, 0, 0, 0, 3, 0, 1'b1, 1'b0);
    plan_row(ACT_LOAD_B, 0, 5, 5, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_TEST, 15, -1, -1, 3, 3, 1'b0, 1'b0);
    // unused action must leave both stores alone
    plan_row(ACT_NONE, 0, -32768, -32768, 31, 31, 1'b0, 1'b0);
    plan_row(ACT_TEST, 0, 32767, 32767, 3, 3, 1'b0, 1'b0);
    // full-range square
    plan_row(ACT_LOAD_A, 0, -32768, -32768, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_LOAD_A, 1, 32767, -32768, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_LOAD_A, 2, 32767, 32767, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_LOAD_A, 3, -32768, 32767, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_TEST, 7, 0, 0, 4, 3, 1'b0, 1'b0);
    // repeated corner gives a zero-length edge
    plan_row(ACT_LOAD_A, 3, 32767, 32767, 0, 0, 1'b0, 1'b0);
    plan_row(ACT_TEST, 7, 0, 0, 4, 3, 1'b0, 1'b0);
    plan_row(ACT_TEST, 0, 0, 0, 1, 1, 1'b0, 1'b0);
    plan_row(ACT_TEST, 0, 0, 0, 2, 3, 1'b0, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan_len; i++)
      issue(plan[i].act, plan[i].slot, plan[i].x, plan[i].y, plan[i].ca, plan[i].cb,
            plan[i].known, plan[i].val);

    while (sent < ITEMS) begin
      idle_mode = (sent / 250) % 4;
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        // keep polygon A now and then so one shape meets several B shapes
        if (na == 0 || !chance(30)) begin
          na  = pick_vertices();
          ra  = pick_radius();
          acx = spread(32767 - ra);
          acy = spread(32767 - ra);
          load_convex(1'b1, na, acx, acy, ra, chance(20));
        end
        nb  = pick_vertices();
        rb  = pick_radius();
        s   = (ra + rb) * 5 / 4 + 1;
        bcx = clamp(acx + spread(s), 32767 - rb);
        bcy = clamp(acy + spread(s), 32767 - rb);
        load_convex(1'b0, nb, bcx, bcy, rb, chance(20));
        repeat ($urandom_range(1, 3)) begin
          ca = chance(15) ? legal_count(1'b1, 1'b1) : na;
          cb = chance(15) ? legal_count(1'b0, 1'b1) : nb;
          issue(ACT_TEST, $urandom_range(0, 15), $urandom, $urandom, ca, cb);
        end
      end else if (roll < 88) begin
        issue(chance(50) ? ACT_LOAD_A : ACT_LOAD_B, $urandom_range(0, 15), $urandom,
              $urandom, $urandom_range(0, 31), $urandom_range(0, 31));
      end else if (roll < 96) begin
        issue(ACT_TEST, $urandom_range(0, 15), $urandom, $urandom,
              legal_count(1'b1, chance(30)), legal_count(1'b0, chance(30)));
      end else begin
        issue(ACT_NONE, $urandom_range(0, 15), $urandom, $urandom,
              $urandom_range(0, 31), $urandom_range(0, 31));
      end
    end

    in_valid_i <= 1'b0;
    idle_mode = IDLE_NONE;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("convex_polygon_overlap_test_test OK");
    end else begin
      $display("convex_polygon_overlap_test_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cpo_pkg.sv
rtl/cpo_vertex_mem.sv
rtl/cpo_proj_unit.sv
rtl/convex_polygon_overlap_test.sv
tb/convex_polygon_overlap_test_test.sv
